/* sv/swrpc_pkg.sv */
// Shared widths, codes and types of the SWR point cache.
`default_nettype none
package swrpc_pkg;

   localparam int ENTRIES_DEFAULT = 8;
   localparam int KEY_W           = 7;
   localparam int SWR_W           = 16;
   localparam int HELD_W          = 4;
   localparam int OP_W            = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_FILL   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0] ind;
      logic [KEY_W-1:0] cap;
   } probe_type;

   typedef struct packed {
      logic [KEY_W-1:0] ind;
      logic [KEY_W-1:0] cap;
      logic [SWR_W-1:0] swr;
   } entry_type;

   typedef struct packed {
      logic             found;
      logic [SWR_W-1:0] swr;
   } chain_type;

endpackage
`default_nettype wire

/* sv/swrpc_req_if.sv */
// Request channel of the SWR point cache: valid, ready and the request item.
`default_nettype none
interface swrpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [swrpc_pkg::OP_W-1:0]     op;
   logic [swrpc_pkg::KEY_W-1:0]    key_l;
   logic [swrpc_pkg::KEY_W-1:0]    key_c;
   logic [swrpc_pkg::SWR_W-1:0]    swr_in;

   modport source (output valid, output op, output key_l, output key_c, output swr_in,
                   input ready);
   modport sink (input valid, input op, input key_l, input key_c, input swr_in,
                 output ready);
endinterface
`default_nettype wire

/* sv/swrpc_rsp_if.sv */
// Response channel of the SWR point cache: valid, ready and the result item.
`default_nettype none
interface swrpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [swrpc_pkg::SWR_W-1:0]    swr_out;
   logic [swrpc_pkg::HELD_W-1:0]   entries_held;

   modport source (output valid, output hit, output swr_out, output entries_held,
                   input ready);
   modport sink (input valid, input hit, input swr_out, input entries_held,
                 output ready);
endinterface
`default_nettype wire

/* sv/swrpc_cell.sv */
// One cache cell: holds an entry, compares it with the probe key and shifts from its neighbour.
`default_nettype none
module swrpc_cell (
   input  wire logic                  clock,
   input  wire logic                  shift,
   input  wire logic                  live,
   input  wire swrpc_pkg::probe_type  probe,
   input  wire swrpc_pkg::entry_type  entry_in,
   output swrpc_pkg::entry_type       entry_out,
   input  wire swrpc_pkg::chain_type  chain_in,
   output swrpc_pkg::chain_type       chain_out
);

   swrpc_pkg::entry_type entry_ff;
   swrpc_pkg::entry_type entry_in_next;
   logic                 match;

   assign match = live && (entry_ff.ind == probe.ind) && (entry_ff.cap == probe.cap);

   always_comb begin
      chain_out.found = chain_in.found | match;
      chain_out.swr   = chain_in.found ? chain_in.swr : entry_ff.swr;
      entry_in_next   = shift ? entry_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in_next;
   end

   assign entry_out = entry_ff;

endmodule
`default_nettype wire

/* sv/swr_point_cache.sv */
// Top level of the SWR point cache: a row of cells, the entry count and the result register.
// A result item is registered and appears in the cycle after its request item is accepted.
// One item per cycle while the result register is free or its result is taken; the key compare
// and the newest-match select ripple along the row of ENTRIES cells within that cycle.
// Reset clears the entry count and the result valid flag; the cell contents stay
// undefined until filled and are never read while beyond the count.
`default_nettype none
module swr_point_cache #(
   parameter int ENTRIES = swrpc_pkg::ENTRIES_DEFAULT
) (
   input wire logic      clock,
   input wire logic      reset,
   swrpc_req_if.sink     req_chan,
   swrpc_rsp_if.source   rsp_chan
);

   localparam int CW = $clog2(ENTRIES + 1);

   swrpc_pkg::op_type    req_op;
   swrpc_pkg::probe_type probe;
   swrpc_pkg::entry_type front;
   swrpc_pkg::entry_type stored [ENTRIES];
   swrpc_pkg::chain_type chain  [ENTRIES+1];
   logic [ENTRIES-1:0]   live;
   logic [ENTRIES-1:0]   shift;
   logic                 accept;
   logic                 any_hit;
   logic                 is_lookup;
   logic                 is_fill;

   logic [CW-1:0]                  count_ff,    count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           hit_ff,       hit_in;
   logic [swrpc_pkg::SWR_W-1:0]    swr_ff,       swr_in;
   logic [swrpc_pkg::HELD_W-1:0]   held_ff,      held_in;

   assign req_op    = swrpc_pkg::op_type'(req_chan.op);
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_lookup = (req_op == swrpc_pkg::OP_LOOKUP);
   assign is_fill   = (req_op == swrpc_pkg::OP_FILL);
   assign any_hit   = chain[ENTRIES].found;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign probe.ind = req_chan.key_l;
   assign probe.cap = req_chan.key_c;

   assign front.ind = req_chan.key_l;
   assign front.cap = req_chan.key_c;
   assign front.swr = is_fill ? req_chan.swr_in : chain[ENTRIES].swr;

   assign chain[0].found = 1'b0;
   assign chain[0].swr   = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      assign live[i]  = (count_ff > CW'(i));
      assign shift[i] = accept && (is_fill || (is_lookup && any_hit && !chain[i].found));
      if (i == 0) begin : g_head
         swrpc_cell u_cell (
            .clock     (clock),
            .shift     (shift[i]),
            .live      (live[i]),
            .probe     (probe),
            .entry_in  (front),
            .entry_out (stored[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
         );
      end else begin : g_body
         swrpc_cell u_cell (
            .clock     (clock),
            .shift     (shift[i]),
            .live      (live[i]),
            .probe     (probe),
            .entry_in  (stored[i-1]),
            .entry_out (stored[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
         );
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      hit_in       = hit_ff;
      swr_in       = swr_ff;
      held_in      = held_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         hit_in = 1'b0;
         swr_in = '0;
         case (req_op)
            swrpc_pkg::OP_LOOKUP: begin
               hit_in = any_hit;
               swr_in = any_hit ? chain[ENTRIES].swr : '0;
            end
            swrpc_pkg::OP_FILL: begin
               swr_in = req_chan.swr_in;
               if (count_ff < CW'(ENTRIES)) begin
                  count_in = count_ff + CW'(1);
               end
            end
            swrpc_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         held_in      = swrpc_pkg::HELD_W'(count_in);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff  <= hit_in;
      swr_ff  <= swr_in;
      held_ff <= held_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = hit_ff;
   assign rsp_chan.swr_out      = swr_ff;
   assign rsp_chan.entries_held = held_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("Entry count exceeds the number of cells.");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == swrpc_pkg::OP_CLEAR) |=> (count_ff == '0) && !rsp_chan.hit)
      else $error("A clear did not empty the cache.");

   a_hit_to_front: assert property (@(posedge clock) disable iff (reset)
      accept && is_lookup && any_hit |=>
         (stored[0].ind == $past(req_chan.key_l)) && (stored[0].cap == $past(req_chan.key_c))
         && rsp_chan.hit && (rsp_chan.swr_out == stored[0].swr))
      else $error("A lookup hit did not move its entry to the front.");

   a_fill_to_front: assert property (@(posedge clock) disable iff (reset)
      accept && is_fill |=> (stored[0].swr == $past(req_chan.swr_in)) && (count_ff != '0))
      else $error("A fill did not write its entry at the front.");
`endif

endmodule
`default_nettype wire
